// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they reduce to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== design/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame allocator package
// Sizes, codes, state encoding and helper functions of the frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

   // Map geometry
   localparam int FRAMES      = 32768;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = (FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int FRAME_SHIFT = 12;

   // Field widths
   localparam int ADDR_W   = 32;
   localparam int CNT_W    = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // Derived widths
   localparam int FRAME_W  = $clog2(FRAMES);
   localparam int RUN_W    = $clog2(FRAMES + 1);
   localparam int WIDX_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W    = $clog2(WORD_BITS);
   localparam int BITCNT_W = $clog2(WORD_BITS + 1);
   localparam int SUM_W    = ((RUN_W > CNT_W) ? RUN_W : CNT_W) + 1;
   localparam int IDX_W    = ADDR_W - FRAME_SHIFT + 1;

   // Constants
   localparam logic [ADDR_W-1:0] BASE_RESET = ADDR_W'(32'h0010_0000);
   localparam logic [IDX_W-1:0]  FRAME_LIMIT = IDX_W'(FRAMES);
   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);
   localparam int LAST_BITS = FRAMES - (MAP_WORDS - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_ONE = 2'd0,
      CMD_ALLOC_RUN = 2'd1,
      CMD_FREE      = 2'd2,
      CMD_CLEAR_ALL = 2'd3
   } bfa_cmd_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_ZERO  = 2'd2,
      STATUS_RANGE = 2'd3
   } bfa_status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MARK_RD,
      S_MARK_WR,
      S_FREE_RD,
      S_FREE_WR,
      S_RESP
   } bfa_state_type;

   // Word unit result
   typedef struct packed {
      logic               found;
      logic [FRAME_W-1:0] found_start;
      logic [RUN_W-1:0]   next_run;
      logic [FRAME_W-1:0] next_start;
   } bfa_scan_type;

   // Map word that holds a frame
   function automatic logic [WIDX_W-1:0] frame_word(input logic [FRAME_W-1:0] f);
      frame_word = WIDX_W'(f >> BIT_W);
   endfunction

   // Bit position of a frame in its map word
   function automatic logic [BIT_W-1:0] frame_bit(input logic [FRAME_W-1:0] f);
      frame_bit = BIT_W'(f);
   endfunction

   // First frame of a map word
   function automatic logic [FRAME_W-1:0] word_frame(input logic [WIDX_W-1:0] w);
      word_frame = FRAME_W'({w, {BIT_W{1'b0}}});
   endfunction

   // Physical address of a frame, wrapping modulo 2^32
   function automatic logic [ADDR_W-1:0] frame_to_addr(
      input logic [ADDR_W-1:0]  base,
      input logic [FRAME_W-1:0] f
   );
      frame_to_addr = base + (ADDR_W'(f) << FRAME_SHIFT);
   endfunction

   // Ones from bit lo up to bit hi inclusive
   function automatic logic [WORD_BITS-1:0] range_mask(
      input logic [BIT_W-1:0] lo,
      input logic [BIT_W-1:0] hi
   );
      logic [WORD_BITS-1:0] ones;
      ones = '1;
      range_mask = (ones << lo) & (ones >> (BIT_W'(WORD_BITS - 1) - hi));
   endfunction

endpackage

// ===== design/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bfa_word_unit.sv =====
// ----------------------------------------------------------------------------
// Frame allocator word unit
// Folds one bitmap word into the first-fit run search and reports a hit.
// ----------------------------------------------------------------------------
module bfa_word_unit
   import bfa_pkg::*;
(
   input  logic [WORD_BITS-1:0] word_used,
   input  logic [WIDX_W-1:0]    word_idx,
   input  logic [RUN_W-1:0]     run_len,
   input  logic [FRAME_W-1:0]   run_start,
   input  logic [CNT_W-1:0]     count,
   output bfa_scan_type         scan
);

   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] used_v;
   logic [FRAME_W-1:0]   word_base;
   logic [BITCNT_W-1:0]  tz;
   logic [BITCNT_W-1:0]  lz;
   logic [SUM_W-1:0]     head_sum;
   logic                 head_hit;
   logic                 count_fits;
   logic [BITCNT_W-1:0]  cnt_small;
   logic [WORD_BITS:0]   len_ext;
   logic [WORD_BITS-1:0] len_mask;
   logic [WORD_BITS-1:0] inner_hits;
   logic [BIT_W-1:0]     inner_pos;
   logic                 inner_hit;
   logic                 all_free;

   // Frames past the end of the map count as used
   assign valid_mask = (word_idx == LAST_WORD) ? LAST_MASK : '1;
   assign used_v     = word_used | ~valid_mask;
   assign word_base  = word_frame(word_idx);
   assign all_free   = (used_v == '0);

   // Free frames from the bottom and from the top of the word
   always_comb begin
      tz = BITCNT_W'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (used_v[i]) begin
            tz = BITCNT_W'(i);
         end
      end
      lz = BITCNT_W'(WORD_BITS);
      for (int i = 0; i < WORD_BITS; i++) begin
         if (used_v[i]) begin
            lz = BITCNT_W'(WORD_BITS - 1 - i);
         end
      end
   end

   // Run carried in from lower words, extended by the bottom free frames
   assign head_sum = SUM_W'(run_len) + SUM_W'(tz);
   assign head_hit = (head_sum >= SUM_W'(count));

   // Runs that lie wholly inside this word
   assign count_fits = (count <= CNT_W'(WORD_BITS));
   assign cnt_small  = BITCNT_W'(count);
   assign len_ext    = ((WORD_BITS + 1)'(1) << cnt_small) - (WORD_BITS + 1)'(1);
   assign len_mask   = len_ext[WORD_BITS-1:0];

   always_comb begin
      for (int s = 0; s < WORD_BITS; s++) begin
         inner_hits[s] = count_fits
            && ((BITCNT_W + 1)'(s) + (BITCNT_W + 1)'(cnt_small)
                <= (BITCNT_W + 1)'(WORD_BITS))
            && (((used_v >> s) & len_mask) == '0);
      end
   end

   // Lowest in-word start
   always_comb begin
      inner_pos = '0;
      for (int s = WORD_BITS - 1; s >= 0; s--) begin
         if (inner_hits[s]) begin
            inner_pos = BIT_W'(s);
         end
      end
   end
   assign inner_hit = |inner_hits;

   // Report the hit or the run carried into the next word
   always_comb begin
      scan.found = head_hit || inner_hit;
      if (head_hit) begin
         scan.found_start = (run_len != '0) ? run_start : word_base;
      end else begin
         scan.found_start = word_base + FRAME_W'(inner_pos);
      end
      if (all_free) begin
         scan.next_run   = run_len + RUN_W'(WORD_BITS);
         scan.next_start = (run_len != '0) ? run_start : word_base;
      end else begin
         scan.next_run   = RUN_W'(lz);
         scan.next_start = word_base + FRAME_W'(WORD_BITS) - FRAME_W'(lz);
      end
   end

endmodule

// ===== design/bitmap_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit allocator of 4 KB frames over a used/free bitmap kept in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command (allocate one, allocate run, free, clear all);
//   a transfer happens when req_valid is high and req_stall is low. Each
//   command gives exactly one rsp_* transfer with frame_address and status.
//   csr_* writes base_address (frame zero); write it only while idle.
// Operation:
//   Allocation scans the bitmap one 32-bit word per cycle through the word
//   unit from word 0, one RAM read behind the address, then marks the run
//   with a read-modify-write (S_MARK_RD, S_MARK_WR) of each word touched.
//   A free clears one bit with a read-modify-write (S_FREE_RD, S_FREE_WR);
//   a zero count or an out-of-range free goes straight to the response.
// Reset:
//   A clearing pass writes all 1024 bitmap words, one per cycle; req_stall
//   stays high until the pass ends.
// Stall:
//   The result sits in an output register; the next command may be taken
//   while it waits. A finished result waits in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_frame_allocator
   import bfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [CNT_W-1:0]    req_count,
   input  logic [ADDR_W-1:0]   req_address,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ADDR_W-1:0]   rsp_frame_address,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [ADDR_W-1:0]   csr_base_address
);

   bfa_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]    base_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WIDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                 dat_vld_ff, dat_vld_in;
   logic [WIDX_W-1:0]    dat_word_ff, dat_word_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic [FRAME_W-1:0]   start_ff, start_in;
   logic [FRAME_W-1:0]   first_ff, first_in;
   logic [FRAME_W-1:0]   last_ff, last_in;
   logic [WIDX_W-1:0]    mark_w_ff, mark_w_in;
   logic [FRAME_W-1:0]   free_idx_ff, free_idx_in;
   logic [WIDX_W-1:0]    clr_ptr_ff, clr_ptr_in;
   logic                 clr_reply_ff, clr_reply_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   bfa_status_type       res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   bfa_status_type       rsp_status_ff, rsp_status_in;

   logic                 req_xfer;
   logic                 out_free;
   logic                 clr_last;
   logic                 dat_last;
   logic                 mark_last;
   logic [ADDR_W-1:0]    free_offset;
   logic                 free_in_range;
   bfa_scan_type         scan;

   logic                 ram_wr_en;
   logic [WIDX_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [WIDX_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic [BIT_W-1:0]     mark_lo;
   logic [BIT_W-1:0]     mark_hi;

   // Handshake terms
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign clr_last  = (clr_ptr_ff == LAST_WORD);
   assign dat_last  = (dat_word_ff == LAST_WORD);
   assign mark_last = (mark_w_ff == frame_word(last_ff));

   // Range check of a free address
   assign free_offset   = req_address - base_ff;
   assign free_in_range = (req_address >= base_ff)
      && ({1'b0, free_offset[ADDR_W-1:FRAME_SHIFT]} < FRAME_LIMIT);

   // Bitmap storage
   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Word unit of the run search
   bfa_word_unit u_word (
      .word_used (ram_rd_data),
      .word_idx  (dat_word_ff),
      .run_len   (run_ff),
      .run_start (start_ff),
      .count     (cnt_ff),
      .scan      (scan)
   );

   // Bit range set in the word under marking
   assign mark_lo = (mark_w_ff == frame_word(first_ff)) ? frame_bit(first_ff) : '0;
   assign mark_hi = (mark_w_ff == frame_word(last_ff)) ? frame_bit(last_ff)
                                                       : BIT_W'(WORD_BITS - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_last) begin
               state_in = clr_reply_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               unique case (bfa_cmd_type'(req_cmd))
                  CMD_ALLOC_ONE: state_in = S_SCAN;
                  CMD_ALLOC_RUN: state_in = (req_count == '0) ? S_RESP : S_SCAN;
                  CMD_FREE:      state_in = free_in_range ? S_FREE_RD : S_RESP;
                  CMD_CLEAR_ALL: state_in = S_CLEAR;
                  default:       state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (dat_vld_ff) begin
               if (scan.found) begin
                  state_in = S_MARK_RD;
               end else if (dat_last) begin
                  state_in = S_RESP;
               end
            end
         end
         S_MARK_RD: state_in = S_MARK_WR;
         S_MARK_WR: state_in = mark_last ? S_RESP : S_MARK_RD;
         S_FREE_RD: state_in = S_FREE_WR;
         S_FREE_WR: state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cnt_in        = cnt_ff;
      rd_ptr_in     = rd_ptr_ff;
      dat_vld_in    = 1'b0;
      dat_word_in   = dat_word_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      mark_w_in     = mark_w_ff;
      free_idx_in   = free_idx_ff;
      clr_ptr_in    = clr_ptr_ff;
      clr_reply_in  = clr_reply_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = clr_ptr_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = rd_ptr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep zeros through the bitmap
            ram_wr_en     = 1'b1;
            ram_wr_addr   = clr_ptr_ff;
            ram_wr_data   = '0;
            clr_ptr_in    = clr_ptr_ff + WIDX_W'(1);
            res_addr_in   = '0;
            res_status_in = STATUS_OK;
         end
         S_IDLE: begin
            // Load a new command
            rd_ptr_in = '0;
            run_in    = '0;
            start_in  = '0;
            if (req_xfer) begin
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               unique case (bfa_cmd_type'(req_cmd))
                  CMD_ALLOC_ONE: cnt_in = CNT_W'(1);
                  CMD_ALLOC_RUN: begin
                     cnt_in = req_count;
                     if (req_count == '0) begin
                        res_status_in = STATUS_ZERO;
                     end
                  end
                  CMD_FREE: begin
                     free_idx_in = FRAME_W'(free_offset >> FRAME_SHIFT);
                     if (!free_in_range) begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  CMD_CLEAR_ALL: begin
                     clr_ptr_in   = '0;
                     clr_reply_in = 1'b1;
                  end
                  default: cnt_in = cnt_ff;
               endcase
            end
         end
         S_SCAN: begin
            // Issue one word read per cycle, fold the word read last cycle
            ram_rd_addr = rd_ptr_ff;
            dat_vld_in  = 1'b1;
            dat_word_in = rd_ptr_ff;
            if (rd_ptr_ff != LAST_WORD) begin
               rd_ptr_in = rd_ptr_ff + WIDX_W'(1);
            end
            if (dat_vld_ff) begin
               run_in   = scan.next_run;
               start_in = scan.next_start;
               if (scan.found) begin
                  first_in      = scan.found_start;
                  last_in       = scan.found_start + FRAME_W'(cnt_ff - CNT_W'(1));
                  mark_w_in     = frame_word(scan.found_start);
                  res_addr_in   = frame_to_addr(base_ff, scan.found_start);
                  res_status_in = STATUS_OK;
               end else if (dat_last) begin
                  res_addr_in   = '0;
                  res_status_in = STATUS_FULL;
               end
            end
         end
         S_MARK_RD: begin
            ram_rd_addr = mark_w_ff;
         end
         S_MARK_WR: begin
            // Set the run's bits in this word and advance
            ram_wr_en   = 1'b1;
            ram_wr_addr = mark_w_ff;
            ram_wr_data = ram_rd_data | range_mask(mark_lo, mark_hi);
            mark_w_in   = mark_w_ff + WIDX_W'(1);
            ram_rd_addr = mark_w_ff;
         end
         S_FREE_RD: begin
            ram_rd_addr = frame_word(free_idx_ff);
         end
         S_FREE_WR: begin
            // Drop the frame's bit
            ram_wr_en   = 1'b1;
            ram_wr_addr = frame_word(free_idx_ff);
            ram_wr_data = ram_rd_data
               & ~(WORD_BITS'(1) << frame_bit(free_idx_ff));
            ram_rd_addr = frame_word(free_idx_ff);
         end
         S_RESP: begin
            clr_reply_in = 1'b0;
         end
         default: ram_rd_addr = rd_ptr_ff;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_RESP) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res_addr_ff;
         rsp_status_in = res_status_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         clr_reply_ff <= 1'b0;
         dat_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_reply_ff <= clr_reply_in;
         dat_vld_ff   <= dat_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_base_address;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_ptr_ff     <= rd_ptr_in;
      dat_word_ff   <= dat_word_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      mark_w_ff     <= mark_w_in;
      free_idx_ff   <= free_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

   // Checks
   `ASSERT_PROP(a_rsp_from_resp, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP),
      "result appeared outside the response state")
   `ASSERT_PROP(a_fail_zero_addr, clock, reset,
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |-> (rsp_addr_ff == '0),
      "failed command returned a nonzero address")
   `ASSERT_PROP(a_busy_after_req, clock, reset,
      req_xfer |=> req_stall,
      "sequencer took a command without leaving idle")
   `ASSERT_NEVER(a_mark_in_run, clock, reset,
      (state_ff == S_MARK_WR) && (mark_w_ff > frame_word(last_ff)),
      "marking ran past the end of the run")

endmodule
